@@ sv/fec_block_receive_window_assert.svh @@
// ----------------------------------------------------------------------------
// fec block receive window assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FEC_BLOCK_RECEIVE_WINDOW_ASSERT_SVH
`define FEC_BLOCK_RECEIVE_WINDOW_ASSERT_SVH

// same-cycle implication, off during reset
`define FBRW_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("fbrw port check failed");

// next-cycle implication, off during reset
`define FBRW_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("fbrw port check failed");

// next-cycle implication, always on
`define FBRW_ASSERT_ALW(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("fbrw port check failed");

`endif

@@ sv/fbrw_pkg.sv @@
// ----------------------------------------------------------------------------
// fbrw_pkg
// shared types and constants of the fec block receive window
// ----------------------------------------------------------------------------
package fbrw_pkg;

  localparam int WINDOW_SLOTS_DEF     = 10;
  localparam int MAX_FRAGMENTS_DEF    = 32;
  localparam int MAX_PACKET_BYTES_DEF = 2048;

  localparam int BLK_W     = 24;
  localparam int FRAG_W    = 8;
  localparam int BYTES_W   = 12;
  localparam int CFG_W     = 6;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 64;
  localparam logic [BLK_W-1:0] STALE_SPAN = 24'd1000;
  localparam logic [BLK_W-1:0] BLK_UNUSED = 24'hFFFFFF;

  localparam logic [1:0] CFG_RX_OFF = 2'd0;
  localparam logic [1:0] CFG_K      = 2'd1;
  localparam logic [1:0] CFG_N      = 2'd2;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_STALE     = 3'd3,
    ST_BAD_FRAG  = 3'd4,
    ST_BEHIND    = 3'd5,
    ST_DUPLICATE = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_SHIFT,
    S_PLACE,
    S_STATUS,
    S_REL
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic place;
    logic is_data;
  } cell_ctrl_t;

endpackage

@@ sv/fbrw_cell.sv @@
// ----------------------------------------------------------------------------
// fbrw_cell
// one window slot: block label, fragment mask and counts, shifts toward slot 0
// ----------------------------------------------------------------------------
module fbrw_cell #(
  parameter int WINDOW_SLOTS  = fbrw_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_FRAGMENTS = fbrw_pkg::MAX_FRAGMENTS_DEF,
  parameter int IDX           = 0,
  localparam int DW = $clog2(2 * WINDOW_SLOTS - 1),
  localparam int OW = $clog2(WINDOW_SLOTS + 1),
  localparam int CW = $clog2(MAX_FRAGMENTS + 1),
  localparam int FI = $clog2(MAX_FRAGMENTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fbrw_pkg::cell_ctrl_t       ctrl,
  input  logic [DW-1:0]              d,
  input  logic [OW-1:0]              occ,
  input  logic [fbrw_pkg::BLK_W-1:0] blk_in,
  input  logic [FI-1:0]              frag,
  input  logic [fbrw_pkg::BLK_W-1:0] nb_blk,
  input  logic [MAX_FRAGMENTS-1:0]   nb_mask,
  input  logic [CW-1:0]              nb_dcnt,
  input  logic [CW-1:0]              nb_pcnt,
  output logic [fbrw_pkg::BLK_W-1:0] blk,
  output logic [MAX_FRAGMENTS-1:0]   mask,
  output logic [CW-1:0]              dcnt,
  output logic [CW-1:0]              pcnt,
  output logic                       dup
);
  import fbrw_pkg::*;

  logic hit;
  logic lbl_en;
  logic [BLK_W-1:0] lbl;

  assign hit = (32'(d) == IDX);
  assign dup = hit && mask[frag];
  assign lbl = blk_in - BLK_W'(d) + BLK_W'(IDX);

  always_comb begin
    if (occ == '0) begin
      lbl_en = (IDX <= 32'(d));
    end else begin
      lbl_en = (32'(d) >= 32'(occ)) && (IDX + 1 >= 32'(occ)) && (IDX <= 32'(d));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      blk  <= BLK_UNUSED;
      mask <= '0;
      dcnt <= '0;
      pcnt <= '0;
    end else if (ctrl.shift) begin
      blk  <= nb_blk;
      mask <= nb_mask;
      dcnt <= nb_dcnt;
      pcnt <= nb_pcnt;
    end else if (ctrl.place) begin
      if (lbl_en) begin
        blk <= lbl;
      end
      if (hit && !mask[frag]) begin
        mask[frag] <= 1'b1;
        if (ctrl.is_data) begin
          dcnt <= dcnt + CW'(1);
        end else begin
          pcnt <= pcnt + CW'(1);
        end
      end
    end
  end

endmodule

@@ sv/fec_block_receive_window.sv @@
// sequence: an accepted fragment is checked, then either dropped with a status beat, or
// shifted as needed, placed and given a status beat followed by any release beats
// throughput: one fragment at a time; a new fragment is taken only once the last is done,
// and output beats wait for the sink; the slot chain shifts one slot per cycle
// reset: synchronous, clears the window, stale mark and output; registers go to 1, 8, 12
// ----------------------------------------------------------------------------
// fec_block_receive_window
// fragment admission and in-order block release over a chain of window slots
// ----------------------------------------------------------------------------
module fec_block_receive_window #(
  parameter int WINDOW_SLOTS     = fbrw_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_FRAGMENTS    = fbrw_pkg::MAX_FRAGMENTS_DEF,
  parameter int MAX_PACKET_BYTES = fbrw_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fbrw_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // block_number, fragment_number, packet_bytes
  input  logic [fbrw_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status_code, released_block, needs_recovery, fragment_mask
  output logic [fbrw_pkg::OUT_DATA_W-1:0] m_tdata,
  // result_kind
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import fbrw_pkg::*;

  localparam int DW = $clog2(2 * WINDOW_SLOTS - 1);
  localparam int OW = $clog2(WINDOW_SLOTS + 1);
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int FI = $clog2(MAX_FRAGMENTS);

  state_t state, state_next;
  cell_ctrl_t ctrl;

  logic             rx_off;
  logic [CFG_W-1:0] k_r;
  logic [CFG_W-1:0] n_r;

  logic [BLK_W-1:0]   blk_r;
  logic [FRAG_W-1:0]  frag_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [OW-1:0]      occ;
  logic [DW-1:0]      d_r;
  logic [DW-1:0]      sh_cnt;
  logic [BLK_W-1:0]   lr;
  logic               lr_valid;
  status_t            code_r;

  logic [BLK_W-1:0]         blk_a  [WINDOW_SLOTS];
  logic [MAX_FRAGMENTS-1:0] mask_a [WINDOW_SLOTS];
  logic [CW-1:0]            dcnt_a [WINDOW_SLOTS];
  logic [CW-1:0]            pcnt_a [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0]  dup_a;

  logic [FRAG_W-1:0] n_eff;
  logic              stale_hit, stale_clr;
  logic [BLK_W:0]    diff;
  logic [BLK_W-1:0]  dval, cval, cc;
  logic              big, mid;
  status_t           chk_code;
  logic [CW:0]       sum0, sum1;
  logic              rel0, rel1, dup_any, out_free;
  logic              load_status, load_rel;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign dup_any  = |dup_a;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_SLOTS; gi++) begin : g_cell
      logic [BLK_W-1:0]         nb_blk;
      logic [MAX_FRAGMENTS-1:0] nb_mask;
      logic [CW-1:0]            nb_dcnt, nb_pcnt;
      if (gi < WINDOW_SLOTS - 1) begin : g_nb
        assign nb_blk  = blk_a[gi+1];
        assign nb_mask = mask_a[gi+1];
        assign nb_dcnt = dcnt_a[gi+1];
        assign nb_pcnt = pcnt_a[gi+1];
      end else begin : g_end
        assign nb_blk  = BLK_UNUSED;
        assign nb_mask = '0;
        assign nb_dcnt = '0;
        assign nb_pcnt = '0;
      end
      fbrw_cell #(
        .WINDOW_SLOTS(WINDOW_SLOTS),
        .MAX_FRAGMENTS(MAX_FRAGMENTS),
        .IDX(gi)
      ) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .d(d_r), .occ(occ),
        .blk_in(blk_r), .frag(frag_r[FI-1:0]),
        .nb_blk(nb_blk), .nb_mask(nb_mask), .nb_dcnt(nb_dcnt), .nb_pcnt(nb_pcnt),
        .blk(blk_a[gi]), .mask(mask_a[gi]), .dcnt(dcnt_a[gi]), .pcnt(pcnt_a[gi]),
        .dup(dup_a[gi])
      );
    end
  endgenerate

  // admission checks
  always_comb begin
    n_eff = (FRAG_W'(n_r) > FRAG_W'(MAX_FRAGMENTS)) ? FRAG_W'(MAX_FRAGMENTS)
                                                   : FRAG_W'(n_r);
    stale_hit = lr_valid && (blk_r <= lr);
    stale_clr = stale_hit && (lr > STALE_SPAN) && (blk_r < lr - STALE_SPAN);
    diff = {1'b0, blk_r} - {1'b0, blk_a[0]};
    dval = (occ == '0) ? '0 : diff[BLK_W-1:0];
    big  = dval >= BLK_W'(2 * WINDOW_SLOTS - 1);
    mid  = dval >= BLK_W'(WINDOW_SLOTS);
    cval = dval - BLK_W'(WINDOW_SLOTS) + BLK_W'(WINDOW_SLOTS / 2);
    cc   = (cval > BLK_W'(WINDOW_SLOTS - 1)) ? BLK_W'(WINDOW_SLOTS - 1) : cval;
    if (rx_off) begin
      chk_code = ST_DISABLED;
    end else if (bytes_r > BYTES_W'(MAX_PACKET_BYTES)) begin
      chk_code = ST_TOO_LONG;
    end else if (stale_hit && !stale_clr) begin
      chk_code = ST_STALE;
    end else if (frag_r >= n_eff) begin
      chk_code = ST_BAD_FRAG;
    end else if (occ != '0 && diff[BLK_W]) begin
      chk_code = ST_BEHIND;
    end else begin
      chk_code = ST_STORED;
    end
  end

  // release conditions on the two leading slots
  always_comb begin
    sum0 = {1'b0, dcnt_a[0]} + {1'b0, pcnt_a[0]};
    sum1 = {1'b0, dcnt_a[1]} + {1'b0, pcnt_a[1]};
    rel0 = (occ != '0) && (32'(sum0) >= 32'(k_r));
    rel1 = (occ > OW'(1)) && (32'(sum1) >= 32'(k_r));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (chk_code != ST_STORED) state_next = S_DROP;
        else if (!big && mid) state_next = S_SHIFT;
        else state_next = S_PLACE;
      end
      S_DROP: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SHIFT: begin
        if (sh_cnt == DW'(1)) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_STATUS;
      S_STATUS: begin
        if (out_free) state_next = (code_r == ST_DUPLICATE || !rel0) ? S_IDLE : S_REL;
      end
      S_REL: begin
        if (out_free && !rel1) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    ctrl = '0;
    ctrl.is_data = (frag_r < FRAG_W'(k_r));
    load_status = 1'b0;
    load_rel = 1'b0;
    case (state)
      S_CHECK:  ctrl.clear = (chk_code == ST_STORED) && big;
      S_DROP:   load_status = out_free;
      S_SHIFT:  ctrl.shift = 1'b1;
      S_PLACE:  ctrl.place = 1'b1;
      S_STATUS: load_status = out_free;
      S_REL: begin
        load_rel = out_free;
        ctrl.shift = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rx_off   <= 1'b1;
      k_r      <= CFG_W'(8);
      n_r      <= CFG_W'(12);
      occ      <= '0;
      lr       <= '0;
      lr_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RX_OFF: rx_off <= cfg_data[0];
          CFG_K:      k_r <= cfg_data;
          CFG_N:      n_r <= cfg_data;
          default:    rx_off <= rx_off;
        endcase
      end
      if (load_status || load_rel) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CHECK: begin
          if (!rx_off && bytes_r <= BYTES_W'(MAX_PACKET_BYTES) && stale_clr) begin
            lr_valid <= 1'b0;
          end
          if (chk_code == ST_STORED && big) occ <= '0;
        end
        S_SHIFT: begin
          if (occ != '0) occ <= occ - OW'(1);
        end
        S_PLACE: begin
          if (occ == '0 || 32'(d_r) >= 32'(occ)) occ <= OW'(d_r) + OW'(1);
        end
        S_REL: begin
          if (load_rel) begin
            lr       <= blk_a[0];
            lr_valid <= 1'b1;
            occ      <= occ - OW'(1);
          end
        end
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      blk_r   <= s_tdata[23:0];
      frag_r  <= s_tdata[31:24];
      bytes_r <= s_tdata[43:32];
    end
    case (state)
      S_CHECK: begin
        code_r <= chk_code;
        if (big) begin
          d_r <= '0;
        end else if (mid) begin
          d_r    <= DW'(dval - cc);
          sh_cnt <= DW'(cc);
        end else begin
          d_r <= DW'(dval);
        end
      end
      S_SHIFT: begin
        sh_cnt <= sh_cnt - DW'(1);
      end
      S_PLACE: begin
        code_r <= dup_any ? ST_DUPLICATE : ST_STORED;
      end
      default: code_r <= code_r;
    endcase
    if (load_status) begin
      m_tuser <= 1'b0;
      m_tdata <= {61'd0, code_r};
      m_tlast <= (state == S_DROP) || (code_r == ST_DUPLICATE) || !rel0;
    end else if (load_rel) begin
      m_tuser <= 1'b1;
      m_tdata <= {4'd0, 32'(mask_a[0]), (32'(dcnt_a[0]) < 32'(k_r)), blk_a[0], 3'd0};
      m_tlast <= !rel1;
    end
  end

endmodule

@@ sv/fbrw_checker.sv @@
// ----------------------------------------------------------------------------
// fbrw_checker
// port-level checks of the fec block receive window, bound to the top level
// ----------------------------------------------------------------------------
`include "fec_block_receive_window_assert.svh"

module fbrw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  `FBRW_ASSERT_ALW(a_reset_idle, clk, rst, !m_tvalid)
  `FBRW_ASSERT_NXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FBRW_ASSERT_IMP(a_status_clean, clk, rst, m_tvalid && !m_tuser, m_tdata[63:3] == 61'd0)
  `FBRW_ASSERT_IMP(a_release_clean, clk, rst, m_tvalid && m_tuser, m_tdata[2:0] == 3'd0)

endmodule

bind fec_block_receive_window fbrw_checker u_fbrw_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ test/tb_fec_block_receive_window.sv @@
// ----------------------------------------------------------------------------
// tb_fec_block_receive_window
// streams fragments into the receive window under random source gaps and sink
// stalls, predicts every status and release beat and checks each one in order
// ----------------------------------------------------------------------------
module tb_fec_block_receive_window;
  import fbrw_pkg::*;

  localparam int SLOTS = WINDOW_SLOTS_DEF;

  typedef struct {
    logic        kind;
    status_t     status;
    logic [23:0] blk;
    logic        rec;
    logic [31:0] mask;
    logic        last;
  } beat_t;

  class window_scoreboard;
    beat_t       pending_beats[$];
    int          errors;
    int          mismatches;
    int          fragments;
    int          releases;
    logic        rx_off;
    int          k_cfg;
    int          n_cfg;
    logic [23:0] slot_blk[SLOTS];
    logic [31:0] slot_bits[SLOTS];
    int          slot_data[SLOTS];
    int          slot_par[SLOTS];
    int          top;
    logic [23:0] last_rel;
    logic        last_rel_ok;

    function new();
      rx_off = 1'b1;
      k_cfg = 8;
      n_cfg = 12;
      for (int i = 0; i < SLOTS; i++) wipe(i);
      top = -1;
      last_rel = '0;
      last_rel_ok = 1'b0;
    endfunction

    function void wipe(int i);
      slot_blk[i] = BLK_UNUSED;
      slot_bits[i] = '0;
      slot_data[i] = 0;
      slot_par[i] = 0;
    endfunction

    function void slide(int c);
      if (c > SLOTS - 1) c = SLOTS - 1;
      for (int i = 0; i < SLOTS - c; i++) begin
        slot_blk[i] = slot_blk[i + c];
        slot_bits[i] = slot_bits[i + c];
        slot_data[i] = slot_data[i + c];
        slot_par[i] = slot_par[i + c];
      end
      top -= c;
      if (top < -1) top = -1;
      for (int i = top + 1; i < SLOTS; i++) wipe(i);
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
        CFG_RX_OFF: rx_off = val[0];
        CFG_K: k_cfg = val;
        CFG_N: n_cfg = val;
        default: ;
      endcase
    endfunction

    function status_t admit(logic [23:0] blk, logic [7:0] frag, logic [11:0] bytes);
      int n;
      int d;
      int c;
      n = (n_cfg > MAX_FRAGMENTS_DEF) ? MAX_FRAGMENTS_DEF : n_cfg;
      if (rx_off) return ST_DISABLED;
      if (bytes > MAX_PACKET_BYTES_DEF) return ST_TOO_LONG;
      if (last_rel_ok && blk <= last_rel) begin
        if (last_rel > STALE_SPAN && blk < last_rel - STALE_SPAN) last_rel_ok = 1'b0;
        else return ST_STALE;
      end
      if (frag >= n) return ST_BAD_FRAG;
      d = (top < 0) ? 0 : int'(blk) - int'(slot_blk[0]);
      if (d < 0) return ST_BEHIND;
      if (d >= 2 * SLOTS - 1) begin
        for (int i = 0; i < SLOTS; i++) wipe(i);
        top = 0;
        slot_blk[0] = blk;
        d = 0;
      end else if (d >= SLOTS) begin
        c = d - SLOTS + SLOTS / 2;
        if (c > SLOTS - 1) c = SLOTS - 1;
        slide(c);
        d -= c;
      end
      if (top < 0) begin
        for (int i = 0; i <= d; i++) slot_blk[i] = blk - 24'(d - i);
        top = d;
      end else if (d > top) begin
        for (int i = top; i <= d; i++) slot_blk[i] = blk - 24'(d - i);
        top = d;
      end
      slot_blk[d] = blk;
      if (slot_bits[d][frag[4:0]]) return ST_DUPLICATE;
      slot_bits[d][frag[4:0]] = 1'b1;
      if (frag < k_cfg) slot_data[d]++;
      else slot_par[d]++;
      return ST_STORED;
    endfunction

    function void note_fragment(logic [23:0] blk, logic [7:0] frag, logic [11:0] bytes);
      beat_t   b;
      beat_t   rel[$];
      status_t st;
      st = admit(blk, frag, bytes);
      fragments++;
      b = '{1'b0, st, 24'd0, 1'b0, 32'd0, 1'b0};
      rel.push_back(b);
      if (st == ST_STORED) begin
        while (top >= 0 && rel.size() <= SLOTS && slot_data[0] + slot_par[0] >= k_cfg) begin
          b = '{1'b1, ST_STORED, slot_blk[0], slot_data[0] < k_cfg, slot_bits[0], 1'b0};
          rel.push_back(b);
          last_rel = slot_blk[0];
          last_rel_ok = 1'b1;
          slide(1);
          releases++;
        end
      end
      rel[rel.size() - 1].last = 1'b1;
      foreach (rel[i]) pending_beats.push_back(rel[i]);
    endfunction

    function void check_beat(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
      beat_t e;
      if (pending_beats.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected output beat kind %0d data %h", kind, data);
        return;
      end
      e = pending_beats.pop_front();
      if (kind !== e.kind || data[2:0] !== e.status || data[26:3] !== e.blk ||
          data[27] !== e.rec || data[59:28] !== e.mask || data[63:60] !== 4'd0 ||
          last !== e.last) begin
        errors++;
        if (mismatches++ < 10)
          $display({"mismatch: exp kind %0d st %0d blk %h rec %0d mask %h last %0d",
                    " / got kind %0d st %0d blk %h rec %0d mask %h last %0d"},
                   e.kind, e.status, e.blk, e.rec, e.mask, e.last,
                   kind, data[2:0], data[26:3], data[27], data[59:28], last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  window_scoreboard sb = new();
  bit               quiet;
  int               k_now;
  int               n_now;
  logic [23:0]      cursor;

  fec_block_receive_window uut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata, m_tlast);

  initial begin
    int w;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_fragment(logic [23:0] blk, logic [7:0] frag, logic [11:0] bytes);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, bytes, frag, blk};
    do @(posedge clk); while (!s_tready);
    sb.note_fragment(blk, frag, bytes);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_beats.size() > 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == CFG_K) k_now = val;
    if (idx == CFG_N) n_now = val;
    @(negedge clk);
  endtask

  task automatic fill_block(logic [23:0] blk, int count);
    for (int f = 0; f < count; f++) send_fragment(blk, 8'(f), 12'd100);
  endtask

  task automatic random_fragment();
    int          r;
    logic [23:0] blk;
    logic [7:0]  frag;
    logic [11:0] bytes;
    r = $urandom_range(0, 99);
    blk = cursor + 24'($urandom_range(0, 1));
    frag = 8'($urandom_range(0, n_now - 1));
    bytes = 12'($urandom_range(0, MAX_PACKET_BYTES_DEF));
    if ($urandom_range(0, k_now + 1) == 0) cursor++;
    if (r < 8) begin
      cursor = cursor + 24'($urandom_range(10, 30));
      blk = cursor;
    end else if (r < 13) blk = cursor - 24'($urandom_range(1, 12));
    else if (r < 17) blk = cursor - 24'($urandom_range(1001, 3000));
    else if (r < 22) bytes = 12'($urandom_range(MAX_PACKET_BYTES_DEF + 1, 4095));
    else if (r < 27) frag = 8'($urandom);
    else if (r < 30) begin
      cursor = 24'($urandom);
      blk = cursor;
    end
    send_fragment(blk, frag, bytes);
  endtask

  initial begin
    int ks[6] = '{8, 1, 32, 3, 4, 1};
    int ns[6] = '{12, 1, 32, 6, 4, 32};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_RX_OFF;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet = 1'b0;
    k_now = 8;
    n_now = 12;
    cursor = 24'd0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reception is off out of reset
    send_fragment(24'hFFFFFF, 8'hFF, 12'hFFF);
    send_fragment(24'd0, 8'd0, 12'd0);
    settle();
    write_reg(CFG_RX_OFF, 6'd0);
    write_reg(CFG_K, 6'd8);
    write_reg(CFG_N, 6'd12);

    send_fragment(24'd0, 8'd0, 12'd0);
    send_fragment(24'd0, 8'd0, 12'd64);
    send_fragment(24'd0, 8'd255, 12'd10);
    send_fragment(24'd0, 8'd11, 12'd4095);
    send_fragment(24'd0, 8'd11, 12'd2048);
    send_fragment(24'd3, 8'd1, 12'd5);
    fill_block(24'd0, 8);
    send_fragment(24'd0, 8'd5, 12'd5);
    send_fragment(24'd25, 8'd0, 12'd5);
    send_fragment(24'd40, 8'd3, 12'd5);
    send_fragment(24'd20, 8'd0, 12'd5);
    fill_block(24'd5000, 8);
    send_fragment(24'd3000, 8'd2, 12'd5);
    settle();

    for (int p = 0; p < 6; p++) begin
      quiet = (p % 3 == 2);
      write_reg(CFG_K, 6'(ks[p]));
      write_reg(CFG_N, 6'(ns[p]));
      cursor = 24'($urandom);
      repeat (72) random_fragment();
      settle();
    end
    quiet = 1'b0;
    write_reg(CFG_RX_OFF, 6'd1);
    repeat (8) random_fragment();
    settle();

    $display("covered %0d fragments and %0d block releases over six k/n settings",
             sb.fragments, sb.releases);
    if (sb.errors == 0) $display("tb_fec_block_receive_window: clean");
    else $display("tb_fec_block_receive_window: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_fec_block_receive_window: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fbrw_pkg.sv
sv/fbrw_cell.sv
sv/fec_block_receive_window.sv
sv/fbrw_checker.sv
test/tb_fec_block_receive_window.sv
